FILE: rtl/prle_pkg.sv
package prle_pkg;

  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 8;
  localparam int RECORD_W  = 24;
  localparam int RGB_W     = 3 * COLOR_W;
  localparam int CFG_IDX_W = 3;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COORD_BITS_DEF    = 12;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_KEY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BROKEN_MODE  = 3'd5;

  localparam logic [COORD_W-1:0] MIN_WIDTH        = 12'd128;
  localparam logic [COORD_W-1:0] RST_IMAGE_WIDTH  = 12'd320;
  localparam logic [COORD_W-1:0] RST_IMAGE_HEIGHT = 12'd200;
  localparam logic [COORD_W-1:0] RST_CLIP_WIDTH   = 12'd320;
  localparam logic [COORD_W-1:0] RST_CLIP_HEIGHT  = 12'd200;

  // colour field above 2047 means a pixel pair
  localparam int PAIR_BIT = RECORD_W - 1;

  typedef struct packed {
    logic [COORD_W-1:0] width;   // already clamped to MIN_WIDTH
    logic [COORD_W-1:0] img_h;
    logic [COORD_W-1:0] clip_w;
    logic [COORD_W-1:0] clip_h;
    logic               alpha_key;
    logic               broken;
  } cfg_t;

  typedef struct packed {
    logic                cmd;
    logic [COLOR_W-1:0]  palette_index;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [RECORD_W-1:0] record;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] len;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               opaque;
  } span_t;

  typedef struct packed {
    span_t span;
    logic  last;
  } out_item_t;

  typedef struct packed {
    logic pal_wr;
    logic rec_load;
    logic step;
    logic rd_b;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_rec;
    logic row_past;
    logic in_is_pair;
    logic run_last;
    logic cand_emit;
    logic step_ok;
    logic hold_valid;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/prle_if.sv
interface prle_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  palette_index;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [23:0] record;

  modport source (output valid, cmd, palette_index, red_in, green_in, blue_in, record,
                  input ready);
  modport sink (input valid, cmd, palette_index, red_in, green_in, blue_in, record,
                output ready);
endinterface

interface prle_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] span_x;
  logic [11:0] span_y;
  logic [11:0] span_len;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic        opaque;
  logic        last;

  modport source (output valid, span_x, span_y, span_len, red_out, green_out, blue_out,
                  opaque, last, input ready);
  modport sink (input valid, span_x, span_y, span_len, red_out, green_out, blue_out,
                opaque, last, output ready);
endinterface

interface prle_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/packed_rle_span_decoder_top.sv
// Packed run-length span decoder.
// in_ch: one item is either a palette write (cmd 0: palette_index, red_in,
//   green_in, blue_in) or a packed record (cmd 1: record, colour in the upper
//   12 bits, count in the lower 12). A record yields zero or more spans.
// out_ch: one item per span (span_x, span_y, span_len, RGB, opaque); last
//   marks the final span of a record.
// cfg_ch: register writes (index, data), always ready; write only while idle.
// A palette write or a record past the image is taken and done in IDLE.
//   A pixel pair walks PAIR1, PAIR2, FLUSH; a run walks RUN, one step per
//   row walked, then FLUSH for the final tag; a stall on out_ch holds a
//   step. Palette colour comes from a registered memory read issued when
//   the record is taken (a pair's second colour on its first step). A span
//   then enters the holding stage; a clipped span still takes a step.
// Output: a one-span holding stage ahead of the output register tags last; a
//   stall on out_ch freezes the row walk, nothing is dropped. A new item is
//   taken while the final span still waits in the output register.
// Reset: registers take their defaults (width 320, height 200, clip 320x200,
//   keying and old-file wrap off), position goes to column 0 row 0. The
//   palette holds garbage until written.
module packed_rle_span_decoder_top #(
  parameter int PALETTE_DEPTH = prle_pkg::PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = prle_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  prle_in_if.sink    in_ch,
  prle_out_if.source out_ch,
  prle_cfg_if.sink   cfg_ch
);
  import prle_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t st;
  in_item_t   in_item;
  out_item_t  out_item;
  logic       out_valid;

  assign in_item.cmd           = in_ch.cmd;
  assign in_item.palette_index = in_ch.palette_index;
  assign in_item.red           = in_ch.red_in;
  assign in_item.green         = in_ch.green_in;
  assign in_item.blue          = in_ch.blue_in;
  assign in_item.record        = in_ch.record;

  prle_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  prle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  prle_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .st        (st),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.valid     = out_valid;
  assign out_ch.span_x    = out_item.span.x;
  assign out_ch.span_y    = out_item.span.y;
  assign out_ch.span_len  = out_item.span.len;
  assign out_ch.red_out   = out_item.span.red;
  assign out_ch.green_out = out_item.span.green;
  assign out_ch.blue_out  = out_item.span.blue;
  assign out_ch.opaque    = out_item.span.opaque;
  assign out_ch.last      = out_item.last;

`ifndef SYNTHESIS
  a_flush_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> st.out_free)
    else $error("flush into a busy output register");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && st.cand_emit && st.hold_valid |-> st.out_free)
    else $error("span pushed while output register busy");

  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !st.hold_valid)
    else $error("item taken with a span still pending");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec_load |=> !in_ch.ready)
    else $error("input ready while a record is being decoded");
`endif

endmodule

FILE: rtl/prle_cfg.sv
module prle_cfg (
  input  logic           clk,
  input  logic           rst_n,
  prle_cfg_if.sink       cfg_ch,
  output prle_pkg::cfg_t cfg
);
  import prle_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IMAGE_WIDTH:  cfg_nxt.width = (cfg_ch.data < MIN_WIDTH) ? MIN_WIDTH : cfg_ch.data;
        REG_IMAGE_HEIGHT: cfg_nxt.img_h = cfg_ch.data;
        REG_CLIP_WIDTH:   cfg_nxt.clip_w = cfg_ch.data;
        REG_CLIP_HEIGHT:  cfg_nxt.clip_h = cfg_ch.data;
        REG_ALPHA_KEY:    cfg_nxt.alpha_key = cfg_ch.data[0];
        REG_BROKEN_MODE:  cfg_nxt.broken = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width     <= RST_IMAGE_WIDTH;
      cfg_r.img_h     <= RST_IMAGE_HEIGHT;
      cfg_r.clip_w    <= RST_CLIP_WIDTH;
      cfg_r.clip_h    <= RST_CLIP_HEIGHT;
      cfg_r.alpha_key <= 1'b0;
      cfg_r.broken    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/prle_ctrl.sv
module prle_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  prle_pkg::dp_status_t  st,
  output prle_pkg::ctrl_cmd_t   cmd
);
  import prle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_PAIR1,
    S_PAIR2,
    S_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!st.in_is_rec) begin
            cmd.pal_wr = 1'b1;
          end else if (!st.row_past) begin
            cmd.rec_load = 1'b1;
            state_nxt    = st.in_is_pair ? S_PAIR1 : S_RUN;
          end
        end
      end
      S_RUN: begin
        if (st.step_ok) begin
          cmd.step = 1'b1;
          if (st.run_last) state_nxt = S_FLUSH;
        end
      end
      S_PAIR1: begin
        if (st.step_ok) begin
          cmd.step  = 1'b1;
          cmd.rd_b  = 1'b1;
          state_nxt = S_PAIR2;
        end
      end
      S_PAIR2: begin
        if (st.step_ok) begin
          cmd.step  = 1'b1;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // last pending span goes out tagged as the record's final one
        if (!st.hold_valid) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/prle_dp.sv
module prle_dp #(
  parameter int PALETTE_DEPTH = prle_pkg::PALETTE_DEPTH_DEF,
  parameter int COORD_BITS    = prle_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  prle_pkg::cfg_t        cfg,
  input  prle_pkg::ctrl_cmd_t   cmd,
  output prle_pkg::dp_status_t  st,
  input  prle_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output prle_pkg::out_item_t   out_item
);
  import prle_pkg::*;

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [COLOR_W:0]   DEPTH_V = (COLOR_W + 1)'(PALETTE_DEPTH);
  localparam logic [COORD_W-1:0] ROW_MAX = COORD_W'((1 << COORD_BITS) - 1);

  // palette memory, one write or one read per cycle
  logic [RGB_W-1:0]   pal_mem [PALETTE_DEPTH];
  logic [RGB_W-1:0]   rd_data_r;
  logic [COLOR_W-1:0] rd_idx_r;
  logic [COLOR_W-1:0] rd_idx;
  logic               rd_en;
  logic               wr_ok;

  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] cnt_r, cnt_nxt;
  logic               pair_r;

  logic               hold_v_r;
  span_t              hold_r;
  logic               out_v_r;
  out_item_t          out_r;

  logic [COORD_W:0]   sum13;
  logic [COORD_W:0]   sub13;
  logic               wrap_run;
  logic [COORD_W-1:0] col_inc;
  logic [COORD_W-1:0] row_inc;
  logic [COORD_W-1:0] cnt_after;
  logic [COORD_W-1:0] cand_len;
  logic               cand_nz;
  logic [COORD_W-1:0] room;
  logic               cand_emit;
  logic [RGB_W-1:0]   rgb_cur;
  span_t              cand;
  logic               out_free;
  logic               load_out;

  assign rd_en  = cmd.rec_load || cmd.rd_b;
  assign rd_idx = cmd.rd_b ? cnt_r[COLOR_W-1:0] : in_item.record[COORD_W +: COLOR_W];
  assign wr_ok  = ({1'b0, in_item.palette_index} < DEPTH_V);

  always_ff @(posedge clk) begin
    if (cmd.pal_wr && wr_ok) begin
      pal_mem[in_item.palette_index[PAL_AW-1:0]] <=
        {in_item.red, in_item.green, in_item.blue};
    end
    if (rd_en) begin
      rd_data_r <= pal_mem[rd_idx[PAL_AW-1:0]];
      rd_idx_r  <= rd_idx;
    end
  end

  // index beyond the palette reads as black
  assign rgb_cur = ({1'b0, rd_idx_r} < DEPTH_V) ? rd_data_r : '0;

  always_comb begin
    sum13     = {1'b0, col_r} + {1'b0, cnt_r};
    wrap_run  = (sum13 >= {1'b0, cfg.width});
    sub13     = {1'b0, cfg.width} + {{COORD_W{1'b0}}, cfg.broken} - {1'b0, col_r};
    cnt_after = ({1'b0, cnt_r} > sub13) ? COORD_W'({1'b0, cnt_r} - sub13) : '0;
    col_inc   = col_r + 1'b1;
    row_inc   = (row_r < ROW_MAX) ? row_r + 1'b1 : row_r;

    if (pair_r) begin
      cand_len = COORD_W'(1);
      cand_nz  = 1'b1;
    end else if (wrap_run) begin
      cand_len = cfg.width - col_r;
      cand_nz  = 1'b1;
    end else begin
      cand_len = cnt_r;
      cand_nz  = (cnt_r != '0);
    end

    room      = cfg.clip_w - col_r;
    cand_emit = cand_nz && (col_r < cfg.clip_w) && (row_r < cfg.clip_h);

    cand.x      = col_r;
    cand.y      = row_r;
    cand.len    = (cand_len > room) ? room : cand_len;
    cand.red    = rgb_cur[2*COLOR_W +: COLOR_W];
    cand.green  = rgb_cur[COLOR_W +: COLOR_W];
    cand.blue   = rgb_cur[0 +: COLOR_W];
    cand.opaque = !(cfg.alpha_key && (rd_idx_r == '0));
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    cnt_nxt = cnt_r;
    if (cmd.rec_load) begin
      cnt_nxt = in_item.record[COORD_W-1:0];
      if (col_r >= cfg.width) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end
    end else if (cmd.step) begin
      if (pair_r) begin
        if (col_inc >= cfg.width) begin
          col_nxt = '0;
          row_nxt = row_inc;
        end else begin
          col_nxt = col_inc;
        end
      end else if (wrap_run) begin
        col_nxt = '0;
        row_nxt = row_inc;
        cnt_nxt = cnt_after;
      end else begin
        col_nxt = sum13[COORD_W-1:0];
      end
    end
  end

  assign out_free = !out_v_r || out_ready;
  assign load_out = hold_v_r && ((cmd.step && cand_emit) || cmd.flush);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cmd.step && cand_emit) begin
        hold_v_r <= 1'b1;
      end else if (cmd.flush) begin
        hold_v_r <= 1'b0;
      end
      out_v_r <= load_out || (out_v_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (cmd.rec_load) pair_r <= in_item.record[PAIR_BIT];
    if (cmd.step && cand_emit) hold_r <= cand;
    if (load_out) begin
      out_r.span <= hold_r;
      out_r.last <= cmd.flush;
    end
  end

  always_comb begin
    st.in_is_rec  = in_item.cmd;
    st.in_is_pair = in_item.record[PAIR_BIT];
    st.row_past   = (row_r >= cfg.img_h);
    st.run_last   = !wrap_run;
    st.cand_emit  = cand_emit;
    st.step_ok    = !(cand_emit && hold_v_r && !out_free);
    st.hold_valid = hold_v_r;
    st.out_free   = out_free;
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

FILE: tb/packed_rle_span_decoder_top_tb.sv
module packed_rle_span_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prle_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 48;
  localparam int LONG_HOLD     = 300;
  localparam int ROW_LIMIT     = 4095;
  localparam int NARROWEST     = 128;

  logic clk = 1'b0;
  logic rst_n;

  prle_in_if  in_ch();
  prle_out_if out_ch();
  prle_cfg_if cfg_ch();

  packed_rle_span_decoder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register mirror and decoder position
  int img_w, img_h, clip_w, clip_h;
  bit key_on, old_wrap;
  int col_pos, row_pos;
  logic [23:0] pal_rgb [256];
  bit pal_written [256];

  out_item_t pending_spans [$];
  int mismatches;
  int src_gap_pct, sink_stall_pct;
  int hold_req;

  // ---------------------------------------------------------------------------
  // span prediction

  function automatic void start_next_row();
    col_pos = 0;
    if (row_pos < ROW_LIMIT) row_pos++;
  endfunction

  function automatic void push_span(int x, int y, int len, int idx);
    out_item_t s;
    if (len == 0 || x >= clip_w || y >= clip_h) return;
    if (len > clip_w - x) len = clip_w - x;
    s.span.x      = x[11:0];
    s.span.y      = y[11:0];
    s.span.len    = len[11:0];
    s.span.red    = pal_rgb[idx][23:16];
    s.span.green  = pal_rgb[idx][15:8];
    s.span.blue   = pal_rgb[idx][7:0];
    s.span.opaque = !(key_on && idx == 0);
    s.last        = 1'b0;
    pending_spans.push_back(s);
  endfunction

  function automatic void predict_spans(in_item_t it);
    int w, colour, count, used, idx, queued;
    queued = pending_spans.size();
    if (it.cmd == 1'b0) begin
      pal_rgb[it.palette_index] = {it.red, it.green, it.blue};
      pal_written[it.palette_index] = 1'b1;
      return;
    end
    if (row_pos >= img_h) return;
    w = (img_w < NARROWEST) ? NARROWEST : img_w;
    if (col_pos >= w) start_next_row();
    colour = int'(it.record[23:12]);
    count  = int'(it.record[11:0]);
    if (colour > 2047) begin
      // pixel pair: both indexes are the low byte of their field
      push_span(col_pos, row_pos, 1, colour & 'hff);
      col_pos++;
      if (col_pos >= w) start_next_row();
      push_span(col_pos, row_pos, 1, count & 'hff);
      col_pos++;
      if (col_pos >= w) start_next_row();
    end else begin
      idx = colour & 'hff;
      while (col_pos + count >= w) begin
        push_span(col_pos, row_pos, w - col_pos, idx);
        used = w + int'(old_wrap) - col_pos;
        count = (count > used) ? count - used : 0;
        start_next_row();
      end
      if (count != 0) begin
        push_span(col_pos, row_pos, count, idx);
        col_pos += count;
      end
    end
    if (pending_spans.size() > queued) pending_spans[pending_spans.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // item builders

  function automatic logic [7:0] pick_color();
    logic [7:0] i;
    do i = 8'($urandom_range(0, 255)); while (!pal_written[i]);
    return i;
  endfunction

  function automatic in_item_t palette_item(logic [7:0] idx, logic [23:0] rgb);
    in_item_t it;
    it.cmd           = 1'b0;
    it.palette_index = idx;
    {it.red, it.green, it.blue} = rgb;
    it.record        = 24'($urandom);
    return it;
  endfunction

  function automatic in_item_t record_item(logic [23:0] word);
    in_item_t it;
    it.cmd           = 1'b1;
    it.palette_index = 8'($urandom);
    it.red           = 8'($urandom);
    it.green         = 8'($urandom);
    it.blue          = 8'($urandom);
    it.record        = word;
    return it;
  endfunction

  function automatic in_item_t run_item(logic [7:0] idx, logic [11:0] count);
    return record_item({1'b0, 3'($urandom), idx, count});
  endfunction

  function automatic in_item_t pair_item(logic [7:0] first, logic [7:0] second);
    return record_item({1'b1, 3'($urandom), first, 4'($urandom), second});
  endfunction

  function automatic in_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return palette_item(8'($urandom), 24'($urandom));
    if (pick < 40) return pair_item(pick_color(), pick_color());
    if (pick < 50) return run_item(pick_color(), 12'($urandom_range(0, 4095)));
    return run_item(pick_color(), 12'($urandom_range(0, 300)));
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= it.cmd;
    in_ch.palette_index <= it.palette_index;
    in_ch.red_in        <= it.red;
    in_ch.green_in      <= it.green;
    in_ch.blue_in       <= it.blue;
    in_ch.record        <= it.record;
    do @(posedge clk); while (!in_ch.ready);
    predict_spans(it);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    // clipped rows still take cycles after the last visible span
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(int w, int h, int cw, int chh, int key, int brk);
    logic [CFG_IDX_W-1:0] reg_ids [6];
    logic [11:0] vals [6];
    wait_idle();
    reg_ids[0] = REG_IMAGE_WIDTH;  vals[0] = 12'(w);
    reg_ids[1] = REG_IMAGE_HEIGHT; vals[1] = 12'(h);
    reg_ids[2] = REG_CLIP_WIDTH;   vals[2] = 12'(cw);
    reg_ids[3] = REG_CLIP_HEIGHT;  vals[3] = 12'(chh);
    reg_ids[4] = REG_ALPHA_KEY;    vals[4] = {11'($urandom), key[0]};
    reg_ids[5] = REG_BROKEN_MODE;  vals[5] = {11'($urandom), brk[0]};
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_ids[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (reg_ids[i])
        REG_IMAGE_WIDTH:  img_w = int'(vals[i]);
        REG_IMAGE_HEIGHT: img_h = int'(vals[i]);
        REG_CLIP_WIDTH:   clip_w = int'(vals[i]);
        REG_CLIP_HEIGHT:  clip_h = int'(vals[i]);
        REG_ALPHA_KEY:    key_on = vals[i][0];
        REG_BROKEN_MODE:  old_wrap = vals[i][0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_palette_setup();
    send_item(palette_item(8'h00, 24'h000000));
    send_item(palette_item(8'hff, 24'hffffff));
    send_item(palette_item(8'h55, 24'($urandom)));
    send_item(palette_item(8'haa, 24'($urandom)));
  endtask

  task automatic test_basic_records();
    send_item(run_item(8'haa, 12'd0));            // zero count: nothing out
    send_item(run_item(8'hff, 12'd1));
    send_item(record_item(24'hfff_fff));          // pair, both fields at max
    send_item(record_item(24'h800_000));          // pair, second field below 2048
    send_item(run_item(8'h55, 12'(320 - col_pos))); // ends exactly on the row edge
    send_item(run_item(8'haa, 12'd4095));
  endtask

  task automatic test_clip_and_keying();
    program_regs(4095, 4095, 100, row_pos + 3, 1, 1);
    send_item(run_item(8'h00, 12'd50));
    send_item(run_item(8'h55, 12'd200));
    send_item(pair_item(8'h00, 8'hff));
    send_item(run_item(8'haa, 12'd4095));
    send_item(run_item(8'hff, 12'd4095));
    // narrow width is clamped; current column is likely past it
    program_regs(0, 4095, 4095, 4095, 0, 1);
    send_item(run_item(8'h55, 12'd10));
    send_item(run_item(8'haa, 12'(NARROWEST - col_pos))); // old-file wrap hits zero
    send_item(run_item(8'hff, 12'd600));
    send_item(pair_item(8'haa, 8'h55));
    program_regs(128, 4095, 1, 4095, 1, 0);
    send_item(run_item(8'h00, 12'd300));
    send_item(pair_item(8'h00, 8'h55));
  endtask

  task automatic test_past_image();
    program_regs(200, row_pos, 4095, 4095, 0, 0);
    send_item(run_item(8'hff, 12'd100));
    send_item(pair_item(8'h55, 8'haa));
  endtask

  task automatic test_random_traffic(int n, int gap, int stall);
    int w, cw;
    src_gap_pct = gap;
    sink_stall_pct = stall;
    case ($urandom_range(0, 9))
      0: w = $urandom_range(0, 127);
      1: w = 4095;
      2: w = 128;
      default: w = $urandom_range(128, 700);
    endcase
    case ($urandom_range(0, 9))
      0: cw = 0;
      1: cw = 4095;
      2: cw = $urandom_range(1, 4095);
      default: cw = $urandom_range(1, 800);
    endcase
    program_regs(w, 4095, cw, 4095, $urandom_range(0, 1), $urandom_range(0, 1));
    repeat (n) send_item(random_item());
  endtask

  task automatic test_backpressure();
    src_gap_pct = 0;
    hold_req <= hold_req + 1;
    repeat (16) begin
      if ($urandom_range(0, 1) == 0) send_item(pair_item(pick_color(), pick_color()));
      else send_item(run_item(pick_color(), 12'($urandom_range(1, 60))));
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side

  initial begin : sink_side
    int hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : span_check
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_spans.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected span: x=%0d y=%0d len=%0d", out_ch.span_x, out_ch.span_y,
                   out_ch.span_len);
      end else begin
        want = pending_spans.pop_front();
        if (out_ch.span_x !== want.span.x || out_ch.span_y !== want.span.y ||
            out_ch.span_len !== want.span.len || out_ch.red_out !== want.span.red ||
            out_ch.green_out !== want.span.green || out_ch.blue_out !== want.span.blue ||
            out_ch.opaque !== want.span.opaque || out_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("span mismatch: exp x=%0d y=%0d len=%0d rgb=%02h%02h%02h op=%0b last=%0b",
                     want.span.x, want.span.y, want.span.len, want.span.red,
                     want.span.green, want.span.blue, want.span.opaque, want.last);
            $display("               got x=%0d y=%0d len=%0d rgb=%02h%02h%02h op=%0b last=%0b",
                     out_ch.span_x, out_ch.span_y, out_ch.span_len, out_ch.red_out,
                     out_ch.green_out, out_ch.blue_out, out_ch.opaque, out_ch.last);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = 1'b0;
    in_ch.palette_index = '0;
    in_ch.red_in        = '0;
    in_ch.green_in      = '0;
    in_ch.blue_in       = '0;
    in_ch.record        = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_IMAGE_WIDTH;
    cfg_ch.data         = '0;
    img_w    = 320;
    img_h    = 200;
    clip_w   = 320;
    clip_h   = 200;
    key_on   = 1'b0;
    old_wrap = 1'b0;
    col_pos  = 0;
    row_pos  = 0;
    mismatches     = 0;
    hold_req       = 0;
    src_gap_pct    = 23;
    sink_stall_pct = 75;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_palette_setup();
    test_basic_records();
    test_clip_and_keying();
    test_past_image();
    test_random_traffic(30, 23, 75);
    test_random_traffic(30, 75, 23);
    test_random_traffic(30, 0, 0);
    test_backpressure();
    wait_idle();

    if (mismatches == 0 && pending_spans.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/prle_pkg.sv
rtl/prle_if.sv
rtl/prle_cfg.sv
rtl/prle_ctrl.sv
rtl/prle_dp.sv
rtl/packed_rle_span_decoder_top.sv
tb/packed_rle_span_decoder_top_tb.sv
